// ----- hdl/vertex_transform_4x4_assert.svh -----
// Assertion macros used by the checker file.
`ifndef VERTEX_TRANSFORM_4X4_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VT4_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vt4 check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define VT4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vt4 check failed");

`endif

// ----- hdl/vt4_pkg.sv -----
package vt4_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int N_ROWS      = 4;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int SHIFT_W     = PROD_W - FRAC_W;
    localparam int SUM_W       = SHIFT_W + 2;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = N_ROWS * DATA_W;

    localparam logic [1:0] ACT_IDENT = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_XFORM = 2'd2;

    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

    typedef logic [DATA_W-1:0] word_t;
    typedef word_t [N_ROWS-1:0] vec_t;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] elem_index;
        word_t      elem_value;
        vec_t       vec;
        vec_t       res;
    } item_t;

    function automatic vec_t ident_row(input logic [1:0] r);
        vec_t row;
        for (int c = 0; c < N_ROWS; c++)
        begin
            row[c] = (2'(c) == r) ? Q_ONE : '0;
        end
        return row;
    endfunction

endpackage

// ----- hdl/vt4_cell.sv -----
module vt4_cell #(
    parameter int ROW = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  vt4_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output vt4_pkg::item_t out_item
);
    import vt4_pkg::*;

    vec_t                      row_reg, row_next;
    logic                      s1_valid_reg, s1_valid_next;
    logic                      s2_valid_reg, s2_valid_next;
    item_t                     s1_item_reg;
    item_t                     s2_item_reg, s2_item_next;
    logic signed [SHIFT_W-1:0] s1_prod_reg [N_ROWS];
    logic signed [SHIFT_W-1:0] s1_prod_next [N_ROWS];
    logic signed [PROD_W-1:0]  prod [N_ROWS];
    logic signed [SUM_W-1:0]   sum;
    word_t                     sat;
    logic                      s1_ready, s2_ready, accept_in;

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign accept_in = in_valid && s1_ready;

    // row update happens as the item enters, so later items see it
    always_comb
    begin
        row_next = row_reg;
        if (accept_in)
        begin
            case (in_item.action)
                ACT_IDENT: row_next = ident_row(2'(ROW));
                ACT_WRITE:
                begin
                    if (in_item.elem_index[3:2] == 2'(ROW))
                        row_next[in_item.elem_index[1:0]] = in_item.elem_value;
                end
                default: ;
            endcase
        end
    end

    // stage 1: four full products, keep floor(p / 2^16)
    always_comb
    begin
        for (int c = 0; c < N_ROWS; c++)
        begin
            prod[c]         = $signed(row_reg[c]) * $signed(in_item.vec[c]);
            s1_prod_next[c] = prod[c][PROD_W-1:FRAC_W];
        end
    end

    // stage 2: exact sum and saturation
    always_comb
    begin
        sum = '0;
        for (int c = 0; c < N_ROWS; c++)
        begin
            sum = sum + SUM_W'(s1_prod_reg[c]);
        end
        if (sum > $signed(SUM_W'(32'h7FFF_FFFF)))
            sat = 32'h7FFF_FFFF;
        else if (sum < -$signed(SUM_W'(33'h1_0000_0000 >> 1)))
            sat = 32'h8000_0000;
        else
            sat = sum[DATA_W-1:0];
        s2_item_next          = s1_item_reg;
        s2_item_next.res[ROW] = sat;
    end

    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= ident_row(2'(ROW));
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_item_reg <= in_item;
            s1_prod_reg <= s1_prod_next;
        end
        if (s2_ready && s1_valid_reg)
            s2_item_reg <= s2_item_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

// ----- hdl/vertex_transform_4x4.sv -----
// Channel  | Dir | Handshake                     | Content
// ---------+-----+-------------------------------+----------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser action, tdata index/value/vec
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata out_x..out_w
//
// One transaction per cycle in both directions unless a stall on m_axis backs up the
// chain; four row cells each run four 32x32 multipliers, so a vector can enter every cycle.
// Each of the four row cells has a product stage and a sum/saturate stage.
// Reset loads the identity into every row cell and empties the chain.
// A stall on m_axis fills the chain stage by stage from the tail; bubbles are
// squeezed out, and identity loads and element writes drop off at the tail.
module vertex_transform_4x4 (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // action [1:0]
    input  logic [1:0]                           s_axis_tuser,
    // elem_index [3:0], elem_value [35:4], vec_x [67:36], vec_y [99:68],
    // vec_z [131:100], vec_w [163:132], zero pad [167:164]
    input  logic [vt4_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
    output logic [vt4_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import vt4_pkg::*;

    logic  chain_valid [N_ROWS+1];
    logic  chain_ready [N_ROWS+1];
    item_t chain_item  [N_ROWS+1];
    logic  tail_xform;

    // Unpack the incoming transaction; results start cleared and each
    // cell fills in its own row.
    always_comb
    begin
        chain_item[0].action     = s_axis_tuser;
        chain_item[0].elem_index = s_axis_tdata[3:0];
        chain_item[0].elem_value = s_axis_tdata[35:4];
        chain_item[0].vec        = s_axis_tdata[163:36];
        chain_item[0].res        = '0;
    end

    assign chain_valid[0] = s_axis_tvalid;
    assign s_axis_tready  = chain_ready[0];

    // Row r of the matrix lives in cell r; the item passes through all
    // four in order, so writes and transforms keep their order per row.
    for (genvar r = 0; r < N_ROWS; r++)
    begin : g_cell
        vt4_cell #(
            .ROW (r)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[r]),
            .in_ready  (chain_ready[r]),
            .in_item   (chain_item[r]),
            .out_valid (chain_valid[r+1]),
            .out_ready (chain_ready[r+1]),
            .out_item  (chain_item[r+1])
        );
    end

    // Only transforms leave the block; drop everything else at the tail.
    assign tail_xform          = (chain_item[N_ROWS].action == ACT_XFORM);
    assign m_axis_tvalid       = chain_valid[N_ROWS] && tail_xform;
    assign chain_ready[N_ROWS] = m_axis_tready || !tail_xform;
    assign m_axis_tdata        = chain_item[N_ROWS].res;

endmodule

// ----- hdl/vt4_checker.sv -----
module vt4_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [1:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [vt4_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import vt4_pkg::*;
    `include "vertex_transform_4x4_assert.svh"

    logic [3:0] pending_reg, pending_next;
    logic       xform_in, result_out;

    assign xform_in   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_XFORM);
    assign result_out = m_axis_tvalid && m_axis_tready;

    // count transforms taken in but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (xform_in && !result_out)
            pending_next = pending_reg + 4'd1;
        else if (!xform_in && result_out)
            pending_next = pending_reg - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    `VT4_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))
    `VT4_ASSERT_NOW(a_ready_when_tail_free, !m_axis_tvalid, s_axis_tready)
    `VT4_ASSERT_NOW(a_no_phantom_result, m_axis_tvalid, pending_reg != 4'd0)
    `VT4_ASSERT_NOW(a_depth_bound, 1'b1, pending_reg <= 4'd8)

endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (.*);

// ----- dv/vertex_transform_4x4_tb.sv -----
module vertex_transform_4x4_tb;

    import vt4_pkg::*;

    // Action code that the block must accept and ignore
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int RAND_ITEMS  = 1700;
    // Run the last stretch of items with no gaps and no stalls
    localparam int QUIET_TAIL  = 300;
    // Abort when this many cycles pass with no transaction on either side
    localparam int STALL_LIMIT = 2000;
    // Drain time after the last result: pipeline latency plus margin
    localparam int DRAIN_CYCLES = 20;

    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = 64'shFFFF_FFFF_8000_0000;

    localparam word_t EDGE_WORDS [0:5] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
        32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000
    };

    // One input transaction; want is only meaningful when fixed is set
    typedef struct packed {
        logic [1:0] action;
        logic [3:0] index;
        word_t      value;
        vec_t       vec;
        logic       fixed;
        vec_t       want;
    } stim_t;

    // Pack components in x, y, z, w order (x lands in the low word)
    function automatic vec_t vxyzw(input word_t x, input word_t y,
                                   input word_t z, input word_t w);
        vec_t v;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        v[3] = w;
        return v;
    endfunction

    // Directed rows. Expected results are typed in only for identity
    // pass-through, saturation extremes and floor-rounding corner cases;
    // every other transform row is checked against the shadow matrix.
    localparam int N_DIRECTED = 25;
    localparam stim_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        // identity after reset passes the vector through untouched
        '{ACT_XFORM, 4'd0, 32'h0,
          vxyzw(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001), 1'b1,
          vxyzw(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001)},
        // zero vector, with element fields set that must be ignored
        '{ACT_XFORM, 4'd15, 32'hFFFF_FFFF,
          vxyzw(32'h0, 32'h0, 32'h0, 32'h0), 1'b1,
          vxyzw(32'h0, 32'h0, 32'h0, 32'h0)},
        // identity load with junk in every unused field
        '{ACT_IDENT, 4'd5, 32'h1234_5678,
          vxyzw(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h5555_AAAA, 32'hAAAA_5555), 1'b0,
          vxyzw(32'h0, 32'h0, 32'h0, 32'h0)},
        // fill row 0 with the largest positive value
        '{ACT_WRITE, 4'd0, 32'h7FFF_FFFF, '0, 1'b0, '0},
        '{ACT_WRITE, 4'd1, 32'h7FFF_FFFF, '0, 1'b0, '0},
        '{ACT_WRITE, 4'd2, 32'h7FFF_FFFF, '0, 1'b0, '0},
        '{ACT_WRITE, 4'd3, 32'h7FFF_FFFF, '0, 1'b0, '0},
        // positive saturation on row 0, pass-through elsewhere
        '{ACT_XFORM, 4'd0, 32'h0,
          vxyzw(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1,
          vxyzw(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF)},
        // negative saturation on row 0, most negative passes elsewhere
        '{ACT_XFORM, 4'd0, 32'h0,
          vxyzw(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1,
          vxyzw(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000)},
        '{ACT_WRITE, 4'd15, 32'h8000_0000, '0, 1'b0, '0},
        // most negative squared saturates high; row 0 saturates low
        '{ACT_XFORM, 4'd0, 32'h0,
          vxyzw(32'h0, 32'h0, 32'h0, 32'h8000_0000), 1'b1,
          vxyzw(32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF)},
        // unused code that would clear m00 if taken as a write
        '{ACT_NONE, 4'd0, 32'h0,
          vxyzw(32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444), 1'b0,
          vxyzw(32'h0, 32'h0, 32'h0, 32'h0)},
        '{ACT_XFORM, 4'd0, 32'h0,
          vxyzw(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000), 1'b0,
          vxyzw(32'h0, 32'h0, 32'h0, 32'h0)},
        '{ACT_IDENT, 4'd0, 32'h0, '0, 1'b0, '0},
        // smallest element: floor rounding of tiny products
        '{ACT_WRITE, 4'd0, 32'h0000_0001, '0, 1'b0, '0},
        '{ACT_XFORM, 4'd0, 32'h0,
          vxyzw(32'hFFFF_FFFF, 32'h0000_0005, 32'h0, 32'h0), 1'b1,
          vxyzw(32'hFFFF_FFFF, 32'h0000_0005, 32'h0, 32'h0)},
        '{ACT_XFORM, 4'd0, 32'h0,
          vxyzw(32'h0000_0001, 32'h0, 32'h0, 32'h0), 1'b1,
          vxyzw(32'h0, 32'h0, 32'h0, 32'h0)},
        '{ACT_WRITE, 4'd10, 32'hFFFF_0000, '0, 1'b0, '0},
        '{ACT_WRITE, 4'd5, 32'h0002_0000, '0, 1'b0, '0},
        '{ACT_XFORM, 4'd0, 32'h0,
          vxyzw(32'h0001_8000, 32'h0003_0000, 32'h7FFF_FFFF, 32'hFFFF_8000), 1'b0,
          vxyzw(32'h0, 32'h0, 32'h0, 32'h0)},
        '{ACT_WRITE, 4'd12, 32'h8000_0000, '0, 1'b0, '0},
        '{ACT_XFORM, 4'd0, 32'h0,
          vxyzw(32'h8000_0000, 32'h0, 32'h0, 32'h0), 1'b0,
          vxyzw(32'h0, 32'h0, 32'h0, 32'h0)},
        '{ACT_WRITE, 4'd7, 32'hC000_0000, '0, 1'b0, '0},
        '{ACT_XFORM, 4'd0, 32'h0,
          vxyzw(32'h4000_0000, 32'hC000_0000, 32'h0000_FFFF, 32'h7FFF_FFFF), 1'b0,
          vxyzw(32'h0, 32'h0, 32'h0, 32'h0)},
        '{ACT_IDENT, 4'd9, 32'h0, '0, 1'b0, '0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [1:0]             s_axis_tuser;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    vertex_transform_4x4 uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the transform matrix, row-major
    word_t  mat_shadow [0:15];
    // Transformed vectors still owed by the block, oldest first
    vec_t   owed_vecs [$];
    stim_t  plan [$];
    stim_t  cur;
    bit     quiet;
    int     errors;
    int     idle_cycles;
    int     n_xform;
    int     n_write;
    int     n_ident;
    int     n_ignored;
    int     n_checked;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic shadow_identity();
        for (int k = 0; k < 16; k++)
        begin
            mat_shadow[k] = (k % 5 == 0) ? Q_ONE : '0;
        end
    endtask

    // Matrix times vector: each full product is floored by 2^16, the four
    // are summed exactly, and the sum clamps to the signed 32-bit range.
    function automatic vec_t transform_vec(input vec_t v);
        vec_t   r;
        longint acc;
        int     m;
        int     c_val;
        for (int row = 0; row < N_ROWS; row++)
        begin
            acc = 0;
            for (int col = 0; col < N_ROWS; col++)
            begin
                m     = mat_shadow[row * 4 + col];
                c_val = v[col];
                acc  += (longint'(m) * longint'(c_val)) >>> FRAC_W;
            end
            if (acc > SAT_HI)
                r[row] = 32'h7FFF_FFFF;
            else if (acc < SAT_LO)
                r[row] = 32'h8000_0000;
            else
                r[row] = acc[31:0];
        end
        return r;
    endfunction

    // Mix full-range words with small Q16.16 values, whole numbers,
    // single set bits and the range extremes
    function automatic word_t rand_word();
        word_t w;
        case ($urandom_range(0, 7))
            0, 1, 2: w = $urandom();
            3, 4:    w = word_t'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            5:       w = word_t'(int'($urandom_range(0, 8)) - 4) << FRAC_W;
            6:       w = word_t'(1) << $urandom_range(0, 31);
            default: w = EDGE_WORDS[$urandom_range(0, 5)];
        endcase
        return w;
    endfunction

    // Hold m_axis_tready low for random bursts; never stall in the quiet tail
    initial
    begin
        m_axis_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Score both channels at the rising edge
    always @(posedge clk)
    begin
        vec_t got;
        vec_t want;
        string names [0:3];
        names = '{"out_x", "out_y", "out_z", "out_w"};
        if (rst_n)
        begin
            idle_cycles++;
            if (s_axis_tvalid && s_axis_tready)
            begin
                idle_cycles = 0;
                case (cur.action)
                    ACT_IDENT:
                    begin
                        shadow_identity();
                        n_ident++;
                    end
                    ACT_WRITE:
                    begin
                        mat_shadow[cur.index] = cur.value;
                        n_write++;
                    end
                    ACT_XFORM:
                    begin
                        owed_vecs.push_back(cur.fixed ? cur.want : transform_vec(cur.vec));
                        n_xform++;
                    end
                    default: n_ignored++;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                idle_cycles = 0;
                got = m_axis_tdata;
                if (owed_vecs.size() == 0)
                begin
                    $error("result %h arrived with none expected", got);
                    errors++;
                end
                else
                begin
                    want = owed_vecs.pop_front();
                    n_checked++;
                    for (int f = 0; f < N_ROWS; f++)
                    begin
                        if (got[f] !== want[f])
                        begin
                            $error("%s expected %h actual %h", names[f], want[f], got[f]);
                            errors++;
                        end
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no transaction for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, owed_vecs.size());
                $display("vertex_transform_4x4: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        stim_t s;
        int    n_rand;
        errors        = 0;
        idle_cycles   = 0;
        n_xform       = 0;
        n_write       = 0;
        n_ident       = 0;
        n_ignored     = 0;
        n_checked     = 0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        cur           = '0;
        shadow_identity();

        // Directed rows first, then random traffic
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            plan.push_back(DIRECTED_ROWS[i]);
        end

        // Mostly transforms interleaved with element writes, with occasional
        // identity reloads; ignored codes ride along but do not count
        n_rand = 0;
        while (n_rand < RAND_ITEMS)
        begin
            s.index = $urandom_range(0, 15);
            s.value = rand_word();
            s.vec   = vxyzw(rand_word(), rand_word(), rand_word(), rand_word());
            s.fixed = 1'b0;
            s.want  = '0;
            case ($urandom_range(0, 19))
                0:             s.action = ACT_IDENT;
                1, 2, 3, 4, 5: s.action = ACT_WRITE;
                6:             s.action = ACT_NONE;
                default:       s.action = ACT_XFORM;
            endcase
            if (s.action != ACT_NONE)
                n_rand++;
            plan.push_back(s);
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < plan.size(); i++)
        begin
            quiet = (i >= plan.size() - QUIET_TAIL);
            // Drop valid for a random burst before some transactions
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            cur = plan[i];
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= cur.action;
            s_axis_tdata  <= {4'b0, cur.vec, cur.value, cur.index};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b0;

        // Wait out the remaining results; the watchdog bounds this
        while (owed_vecs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transforms, %0d element writes, %0d identity loads,",
                 n_xform, n_write, n_ident);
        $display("%0d ignored action codes; %0d results compared", n_ignored, n_checked);
        if (errors == 0)
            $display("vertex_transform_4x4: match");
        else
            $display("vertex_transform_4x4: mismatch");
        $finish;
    end

endmodule
